// File: rtl/tel_pkg.sv
// ----------------------------------------------------------------------------
// tel_pkg
// Shared types and constants of the text buffer line editor.
// ----------------------------------------------------------------------------
package tel_pkg;

    // default store depth
    localparam int unsigned DEPTH_DEF = 4096;

    // fixed widths of the beat fields
    localparam int unsigned OUT_W = 13;
    localparam int unsigned IDX_W = 12;

    // character codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] UPPER_FIRST  = 8'd65;
    localparam logic [7:0] UPPER_LAST   = 8'd90;

    // command opcodes
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_BACKSP = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_UP     = 3'd4,
        OP_DOWN   = 3'd5,
        OP_TOGGLE = 3'd6,
        OP_CLEAR  = 3'd7
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOMOVE = 2'd2
    } t_stat;

    // datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FULL,
        CMD_NOMOVE,
        CMD_SHR_START,
        CMD_SHL_START,
        CMD_INS_WR,
        CMD_BS_FIN,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_TOGGLE,
        CMD_CLEAR,
        CMD_SCAN_START,
        CMD_UP,
        CMD_FWD_START,
        CMD_DOWN,
        CMD_RD_ISSUE,
        CMD_RD_TAKE,
        CMD_PUSH
    } t_cmd;

    // datapath status seen by the controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic cur_zero;
        logic sdone;
    } t_dp_sts;

endpackage

// File: rtl/text_buffer_line_editor.sv
// ----------------------------------------------------------------------------
// text_buffer_line_editor
// Line editor over a byte store with cursor, line/column report and case flag.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result beat. The store is a
// single memory with one read and one write port, walked one byte per cycle:
// insert and backspace shift the (length - cursor) bytes after the cursor,
// up scans the bytes before the cursor, down also scans those after it, and
// every command ends with a scan of the bytes before the final cursor for its
// line and column. The time a command takes grows with the bytes shifted or
// scanned and with the final cursor, plus any wait of the result for the output
// to be free; a new command is taken while the previous result still waits at
// the output.
module text_buffer_line_editor #(
    parameter int unsigned BUFFER_DEPTH = tel_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_opcode,
    input  logic [7:0]                i_char_code,
    input  logic [tel_pkg::IDX_W-1:0] i_read_index,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [tel_pkg::OUT_W-1:0] o_cursor_pos,
    output logic [tel_pkg::OUT_W-1:0] o_length,
    output logic [tel_pkg::OUT_W-1:0] o_line_num,
    output logic [tel_pkg::OUT_W-1:0] o_cursor_col,
    output logic                      o_lower_flag,
    output logic [7:0]                o_read_byte,
    output logic [1:0]                o_status
);
    import tel_pkg::*;

    t_cmd    cmd;
    t_dp_sts sts;

    // sequencer
    tel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // store and registers
    tel_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_cursor_pos (o_cursor_pos),
        .o_length     (o_length),
        .o_line_num   (o_line_num),
        .o_cursor_col (o_cursor_col),
        .o_lower_flag (o_lower_flag),
        .o_read_byte  (o_read_byte),
        .o_status     (o_status)
    );

    // a full-buffer status only with a full length
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_length == OUT_W'(BUFFER_DEPTH))
        else $error("full status with short buffer");

    // no undefined status code
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE || o_status == ST_FULL
                         || o_status == ST_NOMOVE))
        else $error("bad status code");

    // a new command is never taken while the sequencer is busy
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command taken while busy");

endmodule

// File: rtl/tel_dpath.sv
// ----------------------------------------------------------------------------
// tel_dpath
// Text store, length, cursor and case flag, with a one-read one-write
// stream engine that shifts or scans the store one byte per cycle.
// ----------------------------------------------------------------------------
module tel_dpath #(
    parameter int unsigned BUFFER_DEPTH = tel_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tel_pkg::t_cmd             i_cmd,
    output tel_pkg::t_dp_sts          o_sts,
    input  logic [2:0]                i_opcode,
    input  logic [7:0]                i_char_code,
    input  logic [tel_pkg::IDX_W-1:0] i_read_index,
    output logic [tel_pkg::OUT_W-1:0] o_cursor_pos,
    output logic [tel_pkg::OUT_W-1:0] o_length,
    output logic [tel_pkg::OUT_W-1:0] o_line_num,
    output logic [tel_pkg::OUT_W-1:0] o_cursor_col,
    output logic                      o_lower_flag,
    output logic [7:0]                o_read_byte,
    output logic [1:0]                o_status
);
    import tel_pkg::*;

    localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW   = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        M_SHR,
        M_SHL,
        M_LINE,
        M_FWD
    } t_smode;

    logic [7:0] mem [BUFFER_DEPTH];

    // command latches
    t_op              r_op;
    logic [7:0]       r_ch;
    logic [IDX_W-1:0] r_ridx;
    t_stat            r_stat;

    // editor state
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_cur;
    logic          r_flag;

    // scan results
    logic [CW-1:0] r_line;
    logic [CW-1:0] r_curst;
    logic [CW-1:0] r_prvst;
    logic [AW-1:0] r_p;
    logic [AW-1:0] r_q;
    logic          r_f1;
    logic          r_f2;

    // stream engine
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_cnt;
    logic          r_dn;
    t_smode        r_mode;
    logic          r_vld;
    logic [AW-1:0] r_dptr;
    logic [7:0]    r_rdata;
    logic [7:0]    r_rbyte;

    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    ins_ch;
    logic [CW:0]   up_tgt;
    logic [CW:0]   up_stop;
    logic [CW:0]   dn_tgt;
    logic [CW:0]   dn_stop;
    logic          rd_ok;

    // insert character with optional lowercase
    assign ins_ch = (r_flag && r_ch >= UPPER_FIRST && r_ch <= UPPER_LAST)
                  ? r_ch + CASE_OFFSET : r_ch;

    // line move targets, clamped to the end of the target line
    assign up_tgt  = (CW+1)'(r_prvst) + (CW+1)'(r_cur - r_curst);
    assign up_stop = (CW+1)'(r_curst) - 1'b1;
    assign dn_tgt  = (CW+1)'(r_p) + 1'b1 + (CW+1)'(r_cur - r_curst);
    assign dn_stop = r_f2 ? (CW+1)'(r_q) : (CW+1)'(r_len);

    assign rd_ok = CMPW'(r_ridx) < CMPW'(r_len);

    // store ports
    assign rd_addr = (i_cmd == CMD_RD_ISSUE) ? AW'(r_ridx) : r_ptr;

    always_comb begin
        we    = 1'b0;
        waddr = r_dptr;
        wdata = r_rdata;
        if (i_cmd == CMD_INS_WR) begin
            we    = 1'b1;
            waddr = AW'(r_cur);
            wdata = ins_ch;
        end else if (r_vld && r_mode == M_SHR) begin
            we    = 1'b1;
            waddr = r_dptr + 1'b1;
        end else if (r_vld && r_mode == M_SHL) begin
            we    = 1'b1;
            waddr = r_dptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // stream engine and editor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cur  <= '0;
            r_flag <= 1'b0;
            r_cnt  <= '0;
            r_vld  <= 1'b0;
        end else begin
            // one read issued per cycle while bytes remain
            r_vld  <= (r_cnt != '0);
            r_dptr <= r_ptr;
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_ptr <= r_dn ? r_ptr - 1'b1 : r_ptr + 1'b1;
            end

            // returned byte of a scan
            if (r_vld && r_rdata == NEWLINE_CODE) begin
                if (r_mode == M_LINE) begin
                    r_line  <= r_line + 1'b1;
                    r_prvst <= r_curst;
                    r_curst <= CW'(r_dptr) + 1'b1;
                end else if (r_mode == M_FWD) begin
                    if (!r_f1) begin
                        r_f1 <= 1'b1;
                        r_p  <= r_dptr;
                    end else if (!r_f2) begin
                        r_f2 <= 1'b1;
                        r_q  <= r_dptr;
                    end
                end
            end

            case (i_cmd)
                CMD_LOAD: begin
                    r_op   <= t_op'(i_opcode);
                    r_ch   <= i_char_code;
                    r_ridx <= i_read_index;
                    r_stat <= ST_DONE;
                end
                CMD_FULL:   r_stat <= ST_FULL;
                CMD_NOMOVE: r_stat <= ST_NOMOVE;
                CMD_SHR_START: begin
                    r_mode <= M_SHR;
                    r_dn   <= 1'b1;
                    r_ptr  <= AW'(r_len - 1'b1);
                    r_cnt  <= r_len - r_cur;
                end
                CMD_SHL_START: begin
                    r_mode <= M_SHL;
                    r_dn   <= 1'b0;
                    r_ptr  <= AW'(r_cur);
                    r_cnt  <= r_len - r_cur;
                end
                CMD_INS_WR: begin
                    r_len <= r_len + 1'b1;
                    r_cur <= r_cur + 1'b1;
                end
                CMD_BS_FIN: begin
                    r_len <= r_len - 1'b1;
                    r_cur <= r_cur - 1'b1;
                end
                CMD_LEFT: begin
                    if (r_cur == '0) r_stat <= ST_NOMOVE;
                    else r_cur <= r_cur - 1'b1;
                end
                CMD_RIGHT: begin
                    if (r_cur >= r_len) r_stat <= ST_NOMOVE;
                    else r_cur <= r_cur + 1'b1;
                end
                CMD_TOGGLE: r_flag <= ~r_flag;
                CMD_CLEAR: begin
                    r_len <= '0;
                    r_cur <= '0;
                end
                CMD_SCAN_START: begin
                    r_mode  <= M_LINE;
                    r_dn    <= 1'b0;
                    r_ptr   <= '0;
                    r_cnt   <= r_cur;
                    r_line  <= '0;
                    r_curst <= '0;
                    r_prvst <= '0;
                end
                CMD_UP: begin
                    if (r_line == '0) r_stat <= ST_NOMOVE;
                    else r_cur <= CW'((up_tgt > up_stop) ? up_stop : up_tgt);
                end
                CMD_FWD_START: begin
                    r_mode <= M_FWD;
                    r_dn   <= 1'b0;
                    r_ptr  <= AW'(r_cur);
                    r_cnt  <= r_len - r_cur;
                    r_f1   <= 1'b0;
                    r_f2   <= 1'b0;
                end
                CMD_DOWN: begin
                    if (!r_f1) r_stat <= ST_NOMOVE;
                    else r_cur <= CW'((dn_tgt > dn_stop) ? dn_stop : dn_tgt);
                end
                CMD_RD_TAKE: r_rbyte <= rd_ok ? r_rdata : 8'd0;
                CMD_PUSH: begin
                    o_cursor_pos <= OUT_W'(r_cur);
                    o_length     <= OUT_W'(r_len);
                    o_line_num   <= OUT_W'(r_line);
                    o_cursor_col <= OUT_W'(r_cur - r_curst);
                    o_lower_flag <= r_flag;
                    o_read_byte  <= r_rbyte;
                    o_status     <= r_stat;
                end
                default: ;
            endcase
        end
    end

    // status to the controller
    assign o_sts.op       = r_op;
    assign o_sts.full     = (r_len == CW'(BUFFER_DEPTH));
    assign o_sts.cur_zero = (r_cur == '0);
    assign o_sts.sdone    = (r_cnt == '0) && !r_vld;

endmodule

// File: rtl/tel_ctrl.sv
// ----------------------------------------------------------------------------
// tel_ctrl
// Command sequencer: decodes each command, runs the store passes in order
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module tel_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tel_pkg::t_dp_sts i_sts,
    output tel_pkg::t_cmd    o_cmd
);
    import tel_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_DECODE  = 10'b0000000010,
        S_SH_RUN  = 10'b0000000100,
        S_PRE_RUN = 10'b0000001000,
        S_FWD_RUN = 10'b0000010000,
        S_RPT     = 10'b0000100000,
        S_RPT_RUN = 10'b0001000000,
        S_RD_WAIT = 10'b0010000000,
        S_DONE    = 10'b0100000000,
        S_SPARE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    // next state and command
    always_comb begin
        n_state   = r_state;
        o_cmd     = CMD_NONE;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RPT;
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) o_cmd = CMD_FULL;
                        else begin
                            o_cmd   = CMD_SHR_START;
                            n_state = S_SH_RUN;
                        end
                    end
                    OP_BACKSP: begin
                        if (i_sts.cur_zero) o_cmd = CMD_NOMOVE;
                        else begin
                            o_cmd   = CMD_SHL_START;
                            n_state = S_SH_RUN;
                        end
                    end
                    OP_LEFT:   o_cmd = CMD_LEFT;
                    OP_RIGHT:  o_cmd = CMD_RIGHT;
                    OP_TOGGLE: o_cmd = CMD_TOGGLE;
                    OP_CLEAR:  o_cmd = CMD_CLEAR;
                    OP_UP, OP_DOWN: begin
                        o_cmd   = CMD_SCAN_START;
                        n_state = S_PRE_RUN;
                    end
                    default:   o_cmd = CMD_NONE;
                endcase
            end
            S_SH_RUN: begin
                if (i_sts.sdone) begin
                    o_cmd   = (i_sts.op == OP_INSERT) ? CMD_INS_WR : CMD_BS_FIN;
                    n_state = S_RPT;
                end
            end
            S_PRE_RUN: begin
                if (i_sts.sdone) begin
                    if (i_sts.op == OP_UP) begin
                        o_cmd   = CMD_UP;
                        n_state = S_RPT;
                    end else begin
                        o_cmd   = CMD_FWD_START;
                        n_state = S_FWD_RUN;
                    end
                end
            end
            S_FWD_RUN: begin
                if (i_sts.sdone) begin
                    o_cmd   = CMD_DOWN;
                    n_state = S_RPT;
                end
            end
            // line and column of the final cursor
            S_RPT: begin
                o_cmd   = CMD_SCAN_START;
                n_state = S_RPT_RUN;
            end
            S_RPT_RUN: begin
                if (i_sts.sdone) begin
                    o_cmd   = CMD_RD_ISSUE;
                    n_state = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                o_cmd   = CMD_RD_TAKE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd     = CMD_PUSH;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// File: sim/tb_text_buffer_line_editor.sv
// ----------------------------------------------------------------------------
// tb_text_buffer_line_editor
// Drives editing commands through the line editor with random gaps on both
// channels and compares every result beat against a behavioural model of the
// buffer, cursor, line/column and case flag.
// ----------------------------------------------------------------------------
module tb_text_buffer_line_editor;
    timeunit 1ns;
    timeprecision 1ps;
    import tel_pkg::*;

    localparam int unsigned DEPTH = 4096;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic [11:0] ridx;
    } t_cmd_beat;

    typedef struct packed {
        logic [12:0] cur;
        logic [12:0] len;
        logic [12:0] line;
        logic [12:0] col;
        logic        lower;
        logic [7:0]  rbyte;
        t_stat       st;
    } t_res_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_char_code;
    logic [11:0] i_read_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [12:0] o_cursor_pos;
    logic [12:0] o_length;
    logic [12:0] o_line_num;
    logic [12:0] o_cursor_col;
    logic        o_lower_flag;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_status;

    text_buffer_line_editor uut (.*);

    // model state
    logic [7:0] text_mem [DEPTH];
    int         model_len;
    int         cur_pos;
    logic       lower_mode;

    t_cmd_beat  pending_cmds [$];
    t_res_beat  expected_results [$];
    int         errors;
    bit         stim_done;
    bit         hold_sender;
    int         send_gap;
    int         recv_gap;

    function automatic int newlines_upto(int pos);
        int n;
        n = 0;
        for (int i = 0; i < pos; i++) if (text_mem[i] == NEWLINE_CODE) n++;
        return n;
    endfunction

    function automatic int column_at(int pos);
        int c;
        c = 0;
        while (pos > 0 && text_mem[pos-1] != NEWLINE_CODE) begin
            pos--;
            c++;
        end
        return c;
    endfunction

    // move cursor to line at column, clamped to line end
    function automatic void seek_line(int ln, int c);
        int start, stop, seen;
        start = (ln == 0) ? 0 : model_len;
        seen = 0;
        if (ln != 0) begin
            for (int i = 0; i < model_len; i++) begin
                if (text_mem[i] == NEWLINE_CODE) begin
                    seen++;
                    if (seen == ln) begin
                        start = i + 1;
                        break;
                    end
                end
            end
        end
        stop = model_len;
        for (int i = start; i < model_len; i++) begin
            if (text_mem[i] == NEWLINE_CODE) begin
                stop = i;
                break;
            end
        end
        cur_pos = (start + c > stop) ? stop : start + c;
    endfunction

    function automatic t_res_beat edit_and_report(t_cmd_beat b);
        t_res_beat r;
        t_stat st;
        int ln;
        logic [7:0] ch;
        st = ST_DONE;
        ch = b.ch;
        case (b.op)
            OP_INSERT: begin
                if (model_len >= DEPTH) st = ST_FULL;
                else begin
                    if (lower_mode && ch >= UPPER_FIRST && ch <= UPPER_LAST)
                        ch = ch + CASE_OFFSET;
                    for (int i = model_len; i > cur_pos; i--) text_mem[i] = text_mem[i-1];
                    text_mem[cur_pos] = ch;
                    model_len++;
                    cur_pos++;
                end
            end
            OP_BACKSP: begin
                if (cur_pos == 0) st = ST_NOMOVE;
                else begin
                    cur_pos--;
                    for (int i = cur_pos; i + 1 < model_len; i++) text_mem[i] = text_mem[i+1];
                    model_len--;
                    text_mem[model_len] = 8'd0;
                end
            end
            OP_LEFT: if (cur_pos == 0) st = ST_NOMOVE; else cur_pos--;
            OP_RIGHT: if (cur_pos >= model_len) st = ST_NOMOVE; else cur_pos++;
            OP_UP: begin
                ln = newlines_upto(cur_pos);
                if (ln == 0) st = ST_NOMOVE;
                else seek_line(ln - 1, column_at(cur_pos));
            end
            OP_DOWN: begin
                ln = newlines_upto(cur_pos);
                if (ln >= newlines_upto(model_len)) st = ST_NOMOVE;
                else seek_line(ln + 1, column_at(cur_pos));
            end
            OP_TOGGLE: lower_mode = ~lower_mode;
            default: begin
                for (int i = 0; i < DEPTH; i++) text_mem[i] = 8'd0;
                model_len = 0;
                cur_pos = 0;
            end
        endcase
        r.cur   = cur_pos[12:0];
        r.len   = model_len[12:0];
        r.line  = 13'(newlines_upto(cur_pos));
        r.col   = 13'(column_at(cur_pos));
        r.lower = lower_mode;
        r.rbyte = (b.ridx < model_len) ? text_mem[b.ridx] : 8'd0;
        r.st    = st;
        return r;
    endfunction

    function automatic t_cmd_beat mk(t_op op, logic [7:0] ch, logic [11:0] ridx);
        t_cmd_beat b;
        b.op = op;
        b.ch = ch;
        b.ridx = ridx;
        return b;
    endfunction

    // random bytes with frequent newlines and capital letters
    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return NEWLINE_CODE;
        if (k < 5) return 8'($urandom_range(65, 90));
        return 8'($urandom);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold beat
        end else begin
            if (i_in_valid) begin
                expected_results.push_back(edit_and_report(
                    mk(t_op'(i_opcode), i_char_code, i_read_index)));
            end
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !hold_sender) begin
                t_cmd_beat b;
                b = pending_cmds.pop_front();
                i_in_valid   <= 1'b1;
                i_opcode     <= b.op;
                i_char_code  <= b.ch;
                i_read_index <= b.ridx;
                send_gap     <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    t_res_beat e;
                    e = expected_results.pop_front();
                    if (o_cursor_pos !== e.cur) begin
                        $error("cursor_pos exp %0d got %0d", e.cur, o_cursor_pos); errors++;
                    end
                    if (o_length !== e.len) begin
                        $error("length exp %0d got %0d", e.len, o_length); errors++;
                    end
                    if (o_line_num !== e.line) begin
                        $error("line_num exp %0d got %0d", e.line, o_line_num); errors++;
                    end
                    if (o_cursor_col !== e.col) begin
                        $error("cursor_col exp %0d got %0d", e.col, o_cursor_col); errors++;
                    end
                    if (o_lower_flag !== e.lower) begin
                        $error("lower_flag exp %0d got %0d", e.lower, o_lower_flag); errors++;
                    end
                    if (o_read_byte !== e.rbyte) begin
                        $error("read_byte exp %0d got %0d", e.rbyte, o_read_byte); errors++;
                    end
                    if (o_status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, o_status); errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap    <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // stimulus
    initial begin
        errors = 0;
        stim_done = 0;
        hold_sender = 0;
        model_len = 0;
        cur_pos = 0;
        lower_mode = 1'b0;
        for (int i = 0; i < DEPTH; i++) text_mem[i] = 8'd0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_opcode = OP_INSERT;
        i_char_code = 8'd0;
        i_read_index = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: moves on empty buffer, extremes, case handling
        pending_cmds.push_back(mk(OP_BACKSP, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_LEFT, 8'd0, 12'hFFF));
        pending_cmds.push_back(mk(OP_RIGHT, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_UP, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_DOWN, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_INSERT, 8'hFF, 12'd0));
        pending_cmds.push_back(mk(OP_INSERT, 8'd0, 12'd1));
        pending_cmds.push_back(mk(OP_TOGGLE, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_INSERT, 8'd65, 12'd2));
        pending_cmds.push_back(mk(OP_INSERT, 8'd90, 12'd3));
        pending_cmds.push_back(mk(OP_INSERT, 8'd97, 12'd4));
        pending_cmds.push_back(mk(OP_INSERT, NEWLINE_CODE, 12'd4));
        pending_cmds.push_back(mk(OP_TOGGLE, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_INSERT, 8'd77, 12'd5));
        pending_cmds.push_back(mk(OP_UP, 8'd0, 12'd5));
        pending_cmds.push_back(mk(OP_DOWN, 8'd0, 12'd1));
        pending_cmds.push_back(mk(OP_DOWN, 8'd0, 12'd2));
        pending_cmds.push_back(mk(OP_RIGHT, 8'd0, 12'd3));
        pending_cmds.push_back(mk(OP_LEFT, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_BACKSP, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_CLEAR, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_INSERT, 8'd66, 12'd0));

        // wait for everything to drain once
        wait (pending_cmds.size() == 0);
        hold_sender = 1;
        wait (expected_results.size() == 0 && !i_in_valid);
        repeat (20) @(posedge i_clk);
        hold_sender = 0;

        // random: mostly typing and navigating multi-line text
        for (int n = 0; n < 75; n++) begin
            int k;
            t_op op;
            k = $urandom_range(0, 19);
            if (k < 8) op = OP_INSERT;
            else if (k < 10) op = OP_BACKSP;
            else if (k < 12) op = OP_LEFT;
            else if (k < 13) op = OP_RIGHT;
            else if (k < 15) op = OP_UP;
            else if (k < 17) op = OP_DOWN;
            else if (k < 19) op = OP_TOGGLE;
            else op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_LEFT;
            pending_cmds.push_back(mk(op, rand_char(),
                ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40))));
        end

        // closing moves and reads at the index extremes
        pending_cmds.push_back(mk(OP_INSERT, 8'd65, 12'hFFF));
        pending_cmds.push_back(mk(OP_UP, 8'd0, 12'hFFF));
        pending_cmds.push_back(mk(OP_DOWN, 8'd0, 12'd0));
        pending_cmds.push_back(mk(OP_BACKSP, 8'd0, 12'hFFF));
        pending_cmds.push_back(mk(OP_CLEAR, 8'd0, 12'hFFF));

        wait (pending_cmds.size() == 0);
        stim_done = 1;
        wait (expected_results.size() == 0 && !i_in_valid);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // timeout
    initial begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
